>>> rtl/core/key_entry_table_core_macros.svh
// ---------------------------------------------------------------------------
// key_entry_table_core_macros
// Assertion macros shared by the key entry table RTL.
// ---------------------------------------------------------------------------
`ifndef KEY_ENTRY_TABLE_CORE_MACROS_SVH
`define KEY_ENTRY_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define KTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// checked at every edge, reset included
`define KTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define KTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/kte_pkg.sv
// ---------------------------------------------------------------------------
// kte_pkg
// Sizes, codes, records and helpers of the key entry table.
// ---------------------------------------------------------------------------
package kte_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int CHECK_BYTES = 3;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W = 5;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

    localparam logic [23:0] CHECK_MASK = (CHECK_BYTES >= 3) ? 24'hFF_FFFF :
        24'((32'd1 << (8 * CHECK_BYTES)) - 32'd1);

    typedef enum logic [1:0] {
        CMD_ADD       = 2'd0,
        CMD_FIND_TYPE = 2'd1,
        CMD_FIND_ID   = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [63:0] id;
        logic [3:0]  ktype;
        logic [63:0] terminal;
        logic [63:0] wrapped_high;
        logic [63:0] wrapped_low;
        logic [23:0] check;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        t_cmd       op;
        logic       capture;
        logic       clear;
        logic       scan_start;
        logic       issue;
        logic       take_hit;
        logic       write_hit;
        logic       write_new;
        logic       load_out;
        logic [1:0] out_status;
        logic       out_slot;
        logic       out_entry;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic at_end;
        logic full;
        logic out_free;
    } t_ctl_stat;

    // Bytes below the first zero byte (from the top) are forced to zero.
    function automatic logic [63:0] canon_str(input logic [63:0] v);
        logic [63:0] keep;
        logic        run;
        keep = '0;
        run  = 1'b1;
        for (int b = 7; b >= 0; b--) begin
            if (v[8*b +: 8] == 8'h00) run = 1'b0;
            if (run) keep[8*b +: 8] = 8'hFF;
        end
        return v & keep;
    endfunction

endpackage

>>> rtl/core/kte_ctrl.sv
// ---------------------------------------------------------------------------
// kte_ctrl
// Command sequencer: accept, scan the table or clear it, write back, hand off result.
// ---------------------------------------------------------------------------
module kte_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_command,
    output logic                 o_in_stall,
    input  kte_pkg::t_ctl_stat   i_stat,
    output kte_pkg::t_ctl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state        r_state, n_state;
    kte_pkg::t_cmd r_op, n_op;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_res_slot, n_res_slot;
    logic          r_res_entry, n_res_entry;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_entry  = r_res_entry;
        o_cmd        = '0;
        o_cmd.op     = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = kte_pkg::t_cmd'(i_command);
                    if (kte_pkg::t_cmd'(i_command) == kte_pkg::CMD_CLEAR) begin
                        o_cmd.clear  = 1'b1;
                        n_res_status = kte_pkg::ST_OK;
                        n_res_slot   = 1'b0;
                        n_res_entry  = 1'b0;
                        n_state      = S_RESP;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_stat.hit) begin
                    o_cmd.take_hit  = 1'b1;
                    o_cmd.write_hit = (r_op == kte_pkg::CMD_ADD);
                    n_res_status    = kte_pkg::ST_OK;
                    n_res_slot      = 1'b1;
                    n_res_entry     = (r_op != kte_pkg::CMD_ADD);
                    n_state         = S_RESP;
                end else if (i_stat.at_end) begin
                    n_res_entry = 1'b0;
                    if (r_op == kte_pkg::CMD_ADD) begin
                        if (i_stat.full) begin
                            n_res_status = kte_pkg::ST_FULL;
                            n_res_slot   = 1'b0;
                        end else begin
                            o_cmd.write_new = 1'b1;
                            n_res_status    = kte_pkg::ST_OK;
                            n_res_slot      = 1'b1;
                        end
                    end else begin
                        n_res_status = kte_pkg::ST_NOT_FOUND;
                        n_res_slot   = 1'b0;
                    end
                    n_state = S_RESP;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = r_res_status;
                    o_cmd.out_slot   = r_res_slot;
                    o_cmd.out_entry  = r_res_entry;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= kte_pkg::CMD_ADD;
            r_res_status <= kte_pkg::ST_OK;
            r_res_slot   <= 1'b0;
            r_res_entry  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_res_status <= n_res_status;
            r_res_slot   <= n_res_slot;
            r_res_entry  <= n_res_entry;
        end
    end

`include "key_entry_table_core_macros.svh"

    `KTE_ASSERT(a_scan_never_clear, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_op != kte_pkg::CMD_CLEAR), "scan running for a clear command")
    `KTE_ASSERT(a_write_only_on_add, i_clk, i_rst_n, (o_cmd.write_hit || o_cmd.write_new) |-> (r_op == kte_pkg::CMD_ADD), "table write outside add")
    `KTE_ASSERT(a_resp_after_scan_end, i_clk, i_rst_n, ((r_state == S_SCAN) && (i_stat.hit || i_stat.at_end)) |=> (r_state == S_RESP), "scan end did not reach response")

endmodule

>>> rtl/core/kte_datapath.sv
// ---------------------------------------------------------------------------
// kte_datapath
// Entry memory, scan index and match logic, entry count, result register.
// ---------------------------------------------------------------------------
module kte_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kte_pkg::t_ctl_cmd            i_cmd,
    output kte_pkg::t_ctl_stat           o_stat,
    input  logic [63:0]                  i_key_id,
    input  logic [3:0]                   i_key_type,
    input  logic [63:0]                  i_terminal,
    input  logic                         i_terminal_given,
    input  logic [63:0]                  i_wrapped_high,
    input  logic [63:0]                  i_wrapped_low,
    input  logic [23:0]                  i_check_value,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [1:0]                   o_status,
    output logic [kte_pkg::SLOT_W-1:0]   o_slot,
    output logic [63:0]                  o_found_id,
    output logic [3:0]                   o_found_type,
    output logic [63:0]                  o_found_terminal,
    output logic [63:0]                  o_found_wrapped_high,
    output logic [63:0]                  o_found_wrapped_low,
    output logic [23:0]                  o_found_check
);

    kte_pkg::t_entry entry_mem [kte_pkg::MAX_ENTRIES];

    kte_pkg::t_entry                 r_key;
    logic                            r_term_given;
    kte_pkg::t_entry                 r_rd;
    logic [kte_pkg::CNT_W-1:0]       r_count;
    logic [kte_pkg::CNT_W-1:0]       r_idx;
    logic [kte_pkg::IDX_W-1:0]       r_cidx;
    logic                            r_vld;
    logic [kte_pkg::IDX_W-1:0]       r_slot;
    logic                            r_out_valid;
    kte_pkg::t_entry                 r_out;
    logic [1:0]                      r_out_status;
    logic [kte_pkg::IDX_W-1:0]       r_out_slot;

    logic                            match;
    logic                            we;
    logic [kte_pkg::IDX_W-1:0]       waddr;
    kte_pkg::t_entry                 wdata;

    always_comb begin
        unique case (i_cmd.op)
            kte_pkg::CMD_FIND_TYPE:
                match = (r_rd.ktype == r_key.ktype) &&
                        ((r_key.terminal == 64'd0) || (r_rd.terminal == r_key.terminal));
            kte_pkg::CMD_ADD, kte_pkg::CMD_FIND_ID:
                match = (r_rd.id == r_key.id);
            default: match = 1'b0;
        endcase
    end

    assign o_stat.hit      = r_vld && match;
    assign o_stat.at_end   = (r_idx >= r_count);
    assign o_stat.full     = (r_count >= kte_pkg::MAX_COUNT);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // an update keeps the stored terminal unless a new one is given
    always_comb begin
        wdata = r_key;
        if (!r_term_given) wdata.terminal = i_cmd.write_hit ? r_rd.terminal : 64'd0;
    end

    assign we    = i_cmd.write_hit || i_cmd.write_new;
    assign waddr = i_cmd.write_hit ? r_cidx : r_count[kte_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (we) entry_mem[waddr] <= wdata;
        if (i_cmd.issue) r_rd <= entry_mem[r_idx[kte_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key.id           <= kte_pkg::canon_str(i_key_id);
            r_key.ktype        <= i_key_type;
            r_key.terminal     <= kte_pkg::canon_str(i_terminal);
            r_key.wrapped_high <= i_wrapped_high;
            r_key.wrapped_low  <= i_wrapped_low;
            r_key.check        <= i_check_value & kte_pkg::CHECK_MASK;
            r_term_given       <= i_terminal_given;
        end
        if (i_cmd.issue) r_cidx <= r_idx[kte_pkg::IDX_W-1:0];
        if (i_cmd.take_hit) r_slot <= r_cidx;
        else if (i_cmd.write_new) r_slot <= r_count[kte_pkg::IDX_W-1:0];
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_slot   <= i_cmd.out_slot ? r_slot : '0;
            r_out        <= i_cmd.out_entry ? r_rd : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_vld       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld <= i_cmd.issue;
            if (i_cmd.scan_start) r_idx <= '0;
            else if (i_cmd.issue) r_idx <= r_idx + 1'b1;
            if (i_cmd.clear) r_count <= '0;
            else if (i_cmd.write_new) r_count <= r_count + 1'b1;
            if (i_cmd.load_out) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_slot               = kte_pkg::SLOT_W'(r_out_slot);
    assign o_found_id           = r_out.id;
    assign o_found_type         = r_out.ktype;
    assign o_found_terminal     = r_out.terminal;
    assign o_found_wrapped_high = r_out.wrapped_high;
    assign o_found_wrapped_low  = r_out.wrapped_low;
    assign o_found_check        = r_out.check;

`include "key_entry_table_core_macros.svh"

    `KTE_ASSERT_ALWAYS(a_count_bound, i_clk, (!i_rst_n || (r_count <= kte_pkg::MAX_COUNT)), "entry count above table size")
    `KTE_ASSERT(a_append_has_room, i_clk, i_rst_n, i_cmd.write_new |-> (r_count < kte_pkg::MAX_COUNT), "append into a full table")
    `KTE_ASSERT(a_hit_below_count, i_clk, i_rst_n, o_stat.hit |-> (kte_pkg::CNT_W'(r_cidx) < r_count), "hit on an entry past the count")
    `KTE_ASSERT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear |=> (r_count == '0), "clear left entries")

endmodule

>>> rtl/core/key_entry_table_core.sv
// ---------------------------------------------------------------------------
// key_entry_table_core
// Wrapped-key entry table with add/update, find by type, find by id, clear.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one command item; it is
//   taken at an edge with i_in_valid high and o_in_stall low. Output channel
//   o_out_valid / i_out_stall returns exactly one result item per command.
//   Add, find by type and find by id scan the stored entries in order, one
//   entry read from the entry memory per cycle; the read port is registered,
//   so the compare comes in the cycle after the read. The scan ends on the
//   first hit or past the last stored entry; the result is then loaded into
//   the output register once it is free, and the next item can be taken in
//   the cycle after the load. Clear skips the scan.
//   One item is worked at a time; o_in_stall is high from acceptance until
//   the result has been moved into the output register.
//   Reset empties the table (count to zero) and drops any pending result;
//   the entry memory itself is not cleared.
//   While i_out_stall holds a result, the next item may be accepted and
//   scanned; its result waits until the output register frees.
// ---------------------------------------------------------------------------
module key_entry_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_command,
    input  logic [63:0]                  i_key_id,
    input  logic [3:0]                   i_key_type,
    input  logic [63:0]                  i_terminal,
    input  logic                         i_terminal_given,
    input  logic [63:0]                  i_wrapped_high,
    input  logic [63:0]                  i_wrapped_low,
    input  logic [23:0]                  i_check_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [kte_pkg::SLOT_W-1:0]   o_slot,
    output logic [63:0]                  o_found_id,
    output logic [3:0]                   o_found_type,
    output logic [63:0]                  o_found_terminal,
    output logic [63:0]                  o_found_wrapped_high,
    output logic [63:0]                  o_found_wrapped_low,
    output logic [23:0]                  o_found_check
);

    kte_pkg::t_ctl_cmd  ctl_cmd;
    kte_pkg::t_ctl_stat ctl_stat;

    kte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (ctl_stat),
        .o_cmd      (ctl_cmd)
    );

    kte_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (ctl_cmd),
        .o_stat               (ctl_stat),
        .i_key_id             (i_key_id),
        .i_key_type           (i_key_type),
        .i_terminal           (i_terminal),
        .i_terminal_given     (i_terminal_given),
        .i_wrapped_high       (i_wrapped_high),
        .i_wrapped_low        (i_wrapped_low),
        .i_check_value        (i_check_value),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_status             (o_status),
        .o_slot               (o_slot),
        .o_found_id           (o_found_id),
        .o_found_type         (o_found_type),
        .o_found_terminal     (o_found_terminal),
        .o_found_wrapped_high (o_found_wrapped_high),
        .o_found_wrapped_low  (o_found_wrapped_low),
        .o_found_check        (o_found_check)
    );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: key entry table core testbench
// Drives add/update, find by type, find by id and clear commands into the
// table under random input gaps and output stalls. A shadow copy of the table
// gives the answer to each accepted command; answers are compared field by
// field as they leave the core. Covers the empty table, string termination on
// identifiers, terminal keep/overwrite on update, wildcard terminal search,
// the full table and long random traffic with random clears.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 1350;
    localparam int NAME_POOL   = 44;
    localparam int TERM_POOL   = 6;

    typedef struct packed {
        kte_pkg::t_cmd cmd;
        logic [63:0]   key_id;
        logic [3:0]    key_type;
        logic [63:0]   terminal;
        logic          terminal_given;
        logic [63:0]   wrapped_high;
        logic [63:0]   wrapped_low;
        logic [23:0]   check_value;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]                 status;
        logic [kte_pkg::SLOT_W-1:0] slot;
        logic [63:0]                id;
        logic [3:0]                 ktype;
        logic [63:0]                term;
        logic [63:0]                whi;
        logic [63:0]                wlo;
        logic [23:0]                chk;
    } t_table_answer;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                       i_clk;
    logic                       i_rst_n          = 1'b0;
    logic                       i_in_valid       = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_command        = kte_pkg::CMD_FIND_ID;
    logic [63:0]                i_key_id         = '0;
    logic [3:0]                 i_key_type       = '0;
    logic [63:0]                i_terminal       = '0;
    logic                       i_terminal_given = 1'b0;
    logic [63:0]                i_wrapped_high   = '0;
    logic [63:0]                i_wrapped_low    = '0;
    logic [23:0]                i_check_value    = '0;
    logic                       o_out_valid;
    logic                       i_out_stall      = 1'b0;
    logic [1:0]                 o_status;
    logic [kte_pkg::SLOT_W-1:0] o_slot;
    logic [63:0]                o_found_id;
    logic [3:0]                 o_found_type;
    logic [63:0]                o_found_terminal;
    logic [63:0]                o_found_wrapped_high;
    logic [63:0]                o_found_wrapped_low;
    logic [23:0]                o_found_check;

    // shadow table
    kte_pkg::t_entry shadow_mem [kte_pkg::MAX_ENTRIES];
    int unsigned     shadow_count = 0;

    t_table_answer answer_q[$];
    int            error_count    = 0;
    int            items_sent     = 0;
    int unsigned   burst_left     = 0;
    t_stall_mode   r_stall_mode   = STALL_NONE;
    int unsigned   r_stall_left   = 0;

    logic [63:0] name_pool [NAME_POOL];
    logic [63:0] term_pool [TERM_POOL];

    key_entry_table_core u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_key_id             (i_key_id),
        .i_key_type           (i_key_type),
        .i_terminal           (i_terminal),
        .i_terminal_given     (i_terminal_given),
        .i_wrapped_high       (i_wrapped_high),
        .i_wrapped_low        (i_wrapped_low),
        .i_check_value        (i_check_value),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_slot               (o_slot),
        .o_found_id           (o_found_id),
        .o_found_type         (o_found_type),
        .o_found_terminal     (o_found_terminal),
        .o_found_wrapped_high (o_found_wrapped_high),
        .o_found_wrapped_low  (o_found_wrapped_low),
        .o_found_check        (o_found_check)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------

    // identifiers end at the first zero byte; everything after it is dropped
    function automatic logic [63:0] strip_after_nul(input logic [63:0] v);
        logic [63:0] r;
        logic        ended;
        r     = '0;
        ended = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (v[8*b +: 8] == 8'h00) ended = 1'b1;
            if (!ended) r[8*b +: 8] = v[8*b +: 8];
        end
        return r;
    endfunction

    function automatic t_table_answer compute_answer(input t_cmd_item c);
        t_table_answer r;
        logic [63:0]   id;
        logic [63:0]   term;
        int            hit;
        int            n;
        r    = '0;
        id   = strip_after_nul(c.key_id);
        term = strip_after_nul(c.terminal);
        n    = shadow_count;
        hit  = -1;
        case (c.cmd)
            kte_pkg::CMD_ADD: begin
                for (int i = 0; i < n; i++)
                    if (hit < 0 && shadow_mem[i].id == id) hit = i;
                if (hit < 0 && n >= kte_pkg::MAX_ENTRIES) begin
                    r.status = kte_pkg::ST_FULL;
                end else begin
                    if (hit < 0) begin
                        hit                    = n;
                        shadow_count           = n + 1;
                        shadow_mem[hit].id     = id;
                        shadow_mem[hit].terminal = '0;
                    end
                    shadow_mem[hit].ktype        = c.key_type;
                    if (c.terminal_given) shadow_mem[hit].terminal = term;
                    shadow_mem[hit].wrapped_high = c.wrapped_high;
                    shadow_mem[hit].wrapped_low  = c.wrapped_low;
                    shadow_mem[hit].check        = c.check_value & kte_pkg::CHECK_MASK;
                    r.status = kte_pkg::ST_OK;
                    r.slot   = kte_pkg::SLOT_W'(hit % 32);
                end
            end
            kte_pkg::CMD_FIND_TYPE, kte_pkg::CMD_FIND_ID: begin
                for (int i = 0; i < n; i++) begin
                    if (hit >= 0) continue;
                    if (c.cmd == kte_pkg::CMD_FIND_ID) begin
                        if (shadow_mem[i].id == id) hit = i;
                    end else if (shadow_mem[i].ktype == c.key_type &&
                                 (term == '0 || shadow_mem[i].terminal == term)) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = kte_pkg::ST_NOT_FOUND;
                end else begin
                    r.status = kte_pkg::ST_OK;
                    r.slot   = kte_pkg::SLOT_W'(hit % 32);
                    r.id     = shadow_mem[hit].id;
                    r.ktype  = shadow_mem[hit].ktype;
                    r.term   = shadow_mem[hit].terminal;
                    r.whi    = shadow_mem[hit].wrapped_high;
                    r.wlo    = shadow_mem[hit].wrapped_low;
                    r.chk    = shadow_mem[hit].check;
                end
            end
            default: begin
                shadow_count = 0;
                r.status     = kte_pkg::ST_OK;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Answer checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : answer_check
        t_table_answer want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual status %h slot %h",
                         $time, o_status, o_slot);
                error_count++;
            end else begin
                want = answer_q.pop_front();
                check_field("status",             64'(want.status), 64'(o_status));
                check_field("slot",               64'(want.slot),   64'(o_slot));
                check_field("found_id",           want.id,          o_found_id);
                check_field("found_type",         64'(want.ktype),  64'(o_found_type));
                check_field("found_terminal",     want.term,        o_found_terminal);
                check_field("found_wrapped_high", want.whi,         o_found_wrapped_high);
                check_field("found_wrapped_low",  want.wlo,         o_found_wrapped_low);
                check_field("found_check",        64'(want.chk),    64'(o_found_check));
            end
        end
    end

    // receiver stall pattern; its character changes when a random countdown runs out
    always @(posedge i_clk) begin
        if (r_stall_left == 0) begin
            r_stall_mode <= t_stall_mode'($urandom_range(0, 3));
            r_stall_left <= $urandom_range(16, 256);
        end else begin
            r_stall_left <= r_stall_left - 1;
        end
        case (r_stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= r_stall_left[3];
        endcase
    end

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------

    // called right after a rising edge; returns at the accepting edge
    task automatic send_item(input t_cmd_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 19) == 0) gap = 40;
            else if ($urandom_range(0, 3) == 0) gap = 0;
            else gap = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_command        <= it.cmd;
        i_key_id         <= it.key_id;
        i_key_type       <= it.key_type;
        i_terminal       <= it.terminal;
        i_terminal_given <= it.terminal_given;
        i_wrapped_high   <= it.wrapped_high;
        i_wrapped_low    <= it.wrapped_low;
        i_check_value    <= it.check_value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        answer_q.push_back(compute_answer(it));
        items_sent++;
    endtask

    // hold off until every pending answer is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (answer_q.size() != 0);
    endtask

    function automatic t_cmd_item make_item(input kte_pkg::t_cmd c, input logic [63:0] id,
                                            input logic [3:0] ty, input logic [63:0] term,
                                            input logic given, input logic [63:0] hi,
                                            input logic [63:0] lo, input logic [23:0] chk);
        t_cmd_item it;
        it.cmd            = c;
        it.key_id         = id;
        it.key_type       = ty;
        it.terminal       = term;
        it.terminal_given = given;
        it.wrapped_high   = hi;
        it.wrapped_low    = lo;
        it.check_value    = chk;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_name(input int unsigned len);
        logic [63:0] v;
        v = '0;
        for (int b = 0; b < len; b++) v[8*(7-b) +: 8] = 8'($urandom_range(1, 255));
        return v;
    endfunction

    // same string, random garbage after the terminating zero byte
    function automatic logic [63:0] junk_after_nul(input logic [63:0] v);
        logic [63:0] r;
        logic        ended;
        r     = v;
        ended = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (ended) r[8*b +: 8] = 8'($urandom);
            else if (v[8*b +: 8] == 8'h00) ended = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [63:0] pick_name();
        int unsigned r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 12) return rand_word();
        v = name_pool[$urandom_range(0, NAME_POOL - 1)];
        return (r < 40) ? junk_after_nul(v) : v;
    endfunction

    function automatic logic [63:0] pick_terminal();
        int unsigned r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 10) return rand_word();
        v = term_pool[$urandom_range(0, TERM_POOL - 1)];
        return (r < 35) ? junk_after_nul(v) : v;
    endfunction

    // few types most of the time so type searches hit
    function automatic logic [3:0] pick_type();
        if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 3));
        return 4'($urandom);
    endfunction

    function automatic t_cmd_item noise_item();
        return make_item(kte_pkg::t_cmd'($urandom_range(0, 3)), rand_word(), 4'($urandom),
                         rand_word(), 1'($urandom), rand_word(), rand_word(),
                         24'($urandom));
    endfunction

    // clear_rate in parts per thousand
    function automatic t_cmd_item traffic_item(input int unsigned clear_rate);
        t_cmd_item   it;
        int unsigned r;
        it = noise_item();
        r  = $urandom_range(0, 999);
        if (r < clear_rate) begin
            it.cmd = kte_pkg::CMD_CLEAR;
        end else if (r < 50) begin
            // pure noise, command included
        end else if (r < 520) begin
            it.cmd      = kte_pkg::CMD_ADD;
            it.key_id   = pick_name();
            it.key_type = pick_type();
            it.terminal = pick_terminal();
        end else if (r < 780) begin
            it.cmd    = kte_pkg::CMD_FIND_ID;
            it.key_id = pick_name();
        end else begin
            it.cmd      = kte_pkg::CMD_FIND_TYPE;
            it.key_type = pick_type();
            it.terminal = pick_terminal();
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_table();
        send_item(make_item(kte_pkg::CMD_FIND_ID, '0, '0, '0, 1'b0, '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, rand_word(), 4'h0, '0, 1'b1,
                            rand_word(), rand_word(), 24'($urandom)));
        send_item(make_item(kte_pkg::CMD_CLEAR, rand_word(), 4'hF, rand_word(), 1'b1,
                            rand_word(), rand_word(), 24'($urandom)));
    endtask

    task automatic test_corner_entries();
        logic [63:0] ones;
        ones = '1;
        send_item(make_item(kte_pkg::CMD_ADD, ones, 4'hF, ones, 1'b1, ones, ones,
                            24'hFF_FFFF));
        // empty id, no terminal given: junk terminal must not be stored
        send_item(make_item(kte_pkg::CMD_ADD, '0, 4'h0, rand_word(), 1'b0, '0, '0, 24'h0));
        // "A" and a three-char terminal, both with garbage after the zero byte
        send_item(make_item(kte_pkg::CMD_ADD, 64'h4100_DEAD_BEEF_1234, 4'h5,
                            64'h5432_1000_FFFF_FFFF, 1'b1, rand_word(), rand_word(),
                            24'h5A_A5C3));
        send_item(make_item(kte_pkg::CMD_FIND_ID, 64'h4100_0000_0000_0001, 4'h0, '0, 1'b0,
                            '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_ID, ones, 4'h0, '0, 1'b0, '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_ID, 64'h00FF_FFFF_FFFF_FFFF, 4'h0, '0, 1'b0,
                            '0, '0, '0));
        // update keeps the old terminal
        send_item(make_item(kte_pkg::CMD_ADD, 64'h4100_0000_0000_0000, 4'h9,
                            64'h5A00_0000_0000_0000, 1'b0, rand_word(), rand_word(),
                            24'($urandom)));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'h9, '0, 1'b0, '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'h9, 64'h5432_1000_AAAA_AAAA, 1'b0,
                            '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'h9, 64'h5A00_0000_0000_0000, 1'b0,
                            '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'hF, ones, 1'b0, '0, '0, '0));
        // second type-9 entry; search must return the lower slot
        send_item(make_item(kte_pkg::CMD_ADD, 64'h4200_0000_0000_0000, 4'h9, rand_word(),
                            1'b0, rand_word(), rand_word(), 24'($urandom)));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, rand_word(), 4'h9,
                            64'h00AB_0000_0000_0000, 1'b1, '0, '0, '0));
        // update overwrites the terminal when given
        send_item(make_item(kte_pkg::CMD_ADD, 64'h4100_0000_0000_0000, 4'h9,
                            64'h5100_0000_0000_0000, 1'b1, rand_word(), rand_word(),
                            24'($urandom)));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'h9, 64'h5100_0000_0000_0000, 1'b0,
                            '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'h9, 64'h5432_1000_0000_0000, 1'b0,
                            '0, '0, '0));
        // find by id ignores type and terminal
        send_item(make_item(kte_pkg::CMD_FIND_ID, 64'h4200_0000_0000_0000, 4'($urandom),
                            rand_word(), 1'b1, rand_word(), rand_word(), 24'($urandom)));
        send_item(make_item(kte_pkg::CMD_FIND_ID, 64'h4300_0000_0000_0000, 4'h9, '0, 1'b0,
                            '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_ID, ones, 4'hF, '0, 1'b0, '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'hF, '0, 1'b0, '0, '0, '0));
    endtask

    task automatic test_table_full();
        logic [63:0] last_id;
        logic [63:0] tail;
        last_id = '0;
        for (int i = 0; i < kte_pkg::MAX_ENTRIES; i++) begin
            tail    = rand_name(6);
            last_id = {8'h46, 8'(i + 1), tail[63:16]};
            send_item(make_item(kte_pkg::CMD_ADD, last_id, pick_type(), pick_terminal(),
                                1'($urandom), rand_word(), rand_word(), 24'($urandom)));
        end
        tail = rand_name(7);
        send_item(make_item(kte_pkg::CMD_ADD, {8'h47, tail[63:8]}, 4'h3, rand_word(), 1'b1,
                            rand_word(), rand_word(), 24'($urandom)));
        send_item(make_item(kte_pkg::CMD_ADD, junk_after_nul(last_id), 4'h2, pick_terminal(),
                            1'b1, rand_word(), rand_word(), 24'($urandom)));
        send_item(make_item(kte_pkg::CMD_FIND_ID, last_id, '0, '0, 1'b0, '0, '0, '0));
        send_item(make_item(kte_pkg::CMD_FIND_TYPE, '0, 4'h2, pick_terminal(), 1'b0,
                            '0, '0, '0));
        for (int i = 0; i < 8; i++) send_item(traffic_item(0));
        send_item(make_item(kte_pkg::CMD_CLEAR, rand_word(), '0, '0, 1'b0, '0, '0, '0));
    endtask

    task automatic test_random_traffic();
        int unsigned clear_rate;
        int unsigned seg;
        while (items_sent < TOTAL_ITEMS) begin
            // segments without clears let the table fill up
            clear_rate = $urandom_range(0, 1) ? 0 : 30;
            seg        = $urandom_range(60, 200);
            for (int k = 0; k < seg && items_sent < TOTAL_ITEMS; k++)
                send_item(traffic_item(clear_rate));
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
    endtask

    initial begin
        term_pool[0] = '0;
        for (int i = 1; i < TERM_POOL; i++) term_pool[i] = rand_name($urandom_range(1, 8));
        name_pool[0] = '0;
        name_pool[1] = rand_name(8);
        for (int i = 2; i < NAME_POOL; i++) name_pool[i] = rand_name($urandom_range(1, 8));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_corner_entries();
        wait_drained();
        test_table_full();
        test_random_traffic();
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
